FILE: sv/spd_pkg.sv
// Shared types, codes and helpers for the session packet deframer.
package spd_pkg;

   typedef logic [2:0]  kind_type;
   typedef logic [2:0]  class_type;
   typedef logic [1:0]  phase_type;
   typedef logic [16:0] length_type;

   // Result kinds.
   localparam kind_type KIND_HEADER    = 3'd0;
   localparam kind_type KIND_PAYLOAD   = 3'd1;
   localparam kind_type KIND_ERROR     = 3'd2;
   localparam kind_type KIND_RETARGET  = 3'd3;
   localparam kind_type KIND_TRUNCATED = 3'd4;

   // Payload classes.
   localparam class_type CLASS_NAMES    = 3'd0;
   localparam class_type CLASS_NULL     = 3'd1;
   localparam class_type CLASS_ERROR    = 3'd2;
   localparam class_type CLASS_RETARGET = 3'd3;
   localparam class_type CLASS_MESSAGE  = 3'd4;
   localparam class_type CLASS_BAD      = 3'd5;

   // Packet type bytes.
   localparam logic [7:0] TYPE_MESSAGE  = 8'h00;
   localparam logic [7:0] TYPE_REQUEST  = 8'h81;
   localparam logic [7:0] TYPE_POSITIVE = 8'h82;
   localparam logic [7:0] TYPE_NEGATIVE = 8'h83;
   localparam logic [7:0] TYPE_RETARGET = 8'h84;
   localparam logic [7:0] TYPE_KEEPALIVE = 8'h85;

   // Parser phases.
   localparam phase_type PH_HEADER  = 2'd0;
   localparam phase_type PH_PAYLOAD = 2'd1;
   localparam phase_type PH_DROP    = 2'd2;

   // Retarget payload: four address bytes, then two port bytes.
   localparam logic [2:0] ADDR_BYTES    = 3'd4;
   localparam logic [2:0] RETARGET_SIZE = 3'd6;

   // Result queue depth.
   localparam int unsigned QDEPTH = 4;

   typedef struct packed {
      kind_type   result_kind;
      logic [7:0] packet_type;
      class_type  payload_class;
      logic [6:0] header_flags;
      length_type payload_length;
      logic [7:0] out_byte;
      logic [31:0] retarget_addr;
      logic [15:0] retarget_port;
      logic       last;
   } result_type;

   function automatic class_type classify(input logic [7:0] t);
      class_type c;
      unique case (t)
         TYPE_REQUEST:   c = CLASS_NAMES;
         TYPE_POSITIVE:  c = CLASS_NULL;
         TYPE_KEEPALIVE: c = CLASS_NULL;
         TYPE_NEGATIVE:  c = CLASS_ERROR;
         TYPE_RETARGET:  c = CLASS_RETARGET;
         TYPE_MESSAGE:   c = CLASS_MESSAGE;
         default:        c = CLASS_BAD;
      endcase
      return c;
   endfunction

   // Builds one result; header fields read as zero when hdr_valid is low.
   function automatic result_type make_result(
      input kind_type    kind,
      input logic        hdr_valid,
      input logic [7:0]  ptype,
      input class_type   pclass,
      input logic [6:0]  flags,
      input length_type  len,
      input logic [7:0]  obyte,
      input logic [31:0] addr,
      input logic [15:0] port,
      input logic        last);
      result_type r;
      r.result_kind    = kind;
      r.packet_type    = hdr_valid ? ptype  : 8'd0;
      r.payload_class  = hdr_valid ? pclass : CLASS_NAMES;
      r.header_flags   = hdr_valid ? flags  : 7'd0;
      r.payload_length = len;
      r.out_byte       = obyte;
      r.retarget_addr  = addr;
      r.retarget_port  = port;
      r.last           = last;
      return r;
   endfunction

endpackage

FILE: sv/spd_if.sv
// Valid/ready channel interfaces for the deframer's byte input and results.
interface spd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       buffer_end;

   modport source (output valid, output data_byte, output buffer_end, input ready);
   modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface spd_rsp_if;
   logic                valid;
   logic                ready;
   spd_pkg::kind_type   result_kind;
   logic [7:0]          packet_type;
   spd_pkg::class_type  payload_class;
   logic [6:0]          header_flags;
   spd_pkg::length_type payload_length;
   logic [7:0]          out_byte;
   logic [31:0]         retarget_addr;
   logic [15:0]         retarget_port;
   logic                last;

   modport source (output valid, output result_kind, output packet_type,
                   output payload_class, output header_flags, output payload_length,
                   output out_byte, output retarget_addr, output retarget_port,
                   output last, input ready);
   modport sink   (input valid, input result_kind, input packet_type,
                   input payload_class, input header_flags, input payload_length,
                   input out_byte, input retarget_addr, input retarget_port,
                   input last, output ready);
endinterface

FILE: sv/session_packet_deframer_core.sv
// Session packet deframer: header parser, payload classifier and result queue.
//
//   channel   | direction | carries
//   ----------+-----------+----------------------------------------------------
//   req_chan  | in        | one buffer byte per transaction, end-of-buffer flag
//   rsp_chan  | out       | one header, payload, error, retarget or truncation
//
// One byte is accepted per cycle while input ready is high; its parse and state update finish in that cycle.
// A byte yields zero, one or two results, which enter a four-entry result queue
// whose head entry drives rsp_chan.
// Input ready drops while the queue holds more than two results, so a byte that
// yields two results can stall the input, and a stalled result side holds
// the input back for as long as it stalls.
// Synchronous reset empties the queue and returns the parser to the header phase.
module session_packet_deframer_core (
   input logic clock,
   input logic reset,
   spd_req_if.sink   req_chan,
   spd_rsp_if.source rsp_chan
);
   import spd_pkg::*;

   // Parser state.
   phase_type   phase_ff, phase_in;
   logic [1:0]  hcount_ff, hcount_in;
   logic [7:0]  type_ff, type_in;
   logic [6:0]  flags_ff, flags_in;
   length_type  remain_ff, remain_in;
   class_type   class_ff, class_in;
   logic [2:0]  rcount_ff, rcount_in;
   logic [31:0] addr_ff, addr_in;
   logic [15:0] port_ff, port_in;

   // Result queue, head at entry zero.
   result_type  queue_ff [QDEPTH];
   result_type  queue_in [QDEPTH];
   logic [2:0]  count_ff, count_in;

   result_type  res [2];
   logic [1:0]  nres;
   logic        take;
   logic        pop;
   logic [7:0]  b;
   logic        bend;
   logic [2:0]  base;

   assign take = req_chan.valid && req_chan.ready;
   assign pop  = rsp_chan.valid && rsp_chan.ready;
   assign b    = req_chan.data_byte;
   assign bend = req_chan.buffer_end;

   assign req_chan.ready = (count_ff <= 3'(QDEPTH - 2));

   always_comb begin
      phase_in  = phase_ff;
      hcount_in = hcount_ff;
      type_in   = type_ff;
      flags_in  = flags_ff;
      remain_in = remain_ff;
      class_in  = class_ff;
      rcount_in = rcount_ff;
      addr_in   = addr_ff;
      port_in   = port_ff;
      res[0]    = '0;
      res[1]    = '0;
      nres      = 2'd0;

      if (take) begin
         if (phase_ff == PH_PAYLOAD) begin
            remain_in = remain_ff - 17'd1;
            if (class_ff == CLASS_NAMES || class_ff == CLASS_MESSAGE) begin
               res[0] = make_result(KIND_PAYLOAD, 1'b1, type_ff, class_ff, flags_ff,
                                    '0, b, 32'd0, 16'd0, remain_in == '0);
               nres   = 2'd1;
            end else if (class_ff == CLASS_ERROR && rcount_ff == 3'd0) begin
               addr_in = {24'd0, b};
            end else if (class_ff == CLASS_RETARGET) begin
               if (rcount_ff < ADDR_BYTES) begin
                  addr_in = {addr_ff[23:0], b};
               end else if (rcount_ff < RETARGET_SIZE) begin
                  port_in = {port_ff[7:0], b};
               end
            end
            if (rcount_ff < RETARGET_SIZE) begin
               rcount_in = rcount_ff + 3'd1;
            end
            if (remain_in == '0) begin
               // The error and retarget results are only reported once the
               // payload is complete.
               if (class_ff == CLASS_ERROR) begin
                  res[nres[0]] = make_result(KIND_ERROR, 1'b1, type_ff, class_ff, flags_ff,
                                             '0, addr_in[7:0], 32'd0, 16'd0, 1'b1);
                  nres = nres + 2'd1;
               end else if (class_ff == CLASS_RETARGET && rcount_in == RETARGET_SIZE) begin
                  res[nres[0]] = make_result(KIND_RETARGET, 1'b1, type_ff, class_ff,
                                             flags_ff, '0, 8'd0, addr_in, port_in, 1'b1);
                  nres = nres + 2'd1;
               end
               phase_in = PH_DROP;
            end else if (bend) begin
               res[nres[0]] = make_result(KIND_TRUNCATED, 1'b1, type_ff, class_ff, flags_ff,
                                          '0, 8'd0, 32'd0, 16'd0, 1'b1);
               nres = nres + 2'd1;
            end
         end else if (phase_ff == PH_HEADER) begin
            unique case (hcount_ff)
               2'd0: begin
                  type_in   = b;
                  hcount_in = 2'd1;
               end
               2'd1: begin
                  flags_in  = b[7:1];
                  remain_in = {b[0], 16'd0};
                  hcount_in = 2'd2;
               end
               2'd2: begin
                  remain_in = {remain_ff[16], b, 8'd0};
                  hcount_in = 2'd3;
               end
               default: begin
                  remain_in = {remain_ff[16:8], b};
                  hcount_in = 2'd0;
                  class_in  = classify(type_ff);
                  rcount_in = 3'd0;
                  addr_in   = 32'd0;
                  port_in   = 16'd0;
                  res[0] = make_result(KIND_HEADER, 1'b1, type_ff, class_in, flags_ff,
                                       remain_in, 8'd0, 32'd0, 16'd0, remain_in == '0);
                  nres   = 2'd1;
                  phase_in = (remain_in != '0) ? PH_PAYLOAD : PH_DROP;
                  if (bend && remain_in != '0) begin
                     res[1] = make_result(KIND_TRUNCATED, 1'b1, type_ff, class_in,
                                          flags_ff, '0, 8'd0, 32'd0, 16'd0, 1'b1);
                     nres   = 2'd2;
                  end
               end
            endcase
            // A buffer that ends inside the header gives a bare truncation.
            if (bend && phase_in == PH_HEADER && hcount_in != 2'd0) begin
               res[0] = make_result(KIND_TRUNCATED, 1'b0, type_in, class_in, flags_in,
                                    '0, 8'd0, 32'd0, 16'd0, 1'b1);
               nres   = 2'd1;
            end
         end
         if (bend) begin
            phase_in  = PH_HEADER;
            hcount_in = 2'd0;
         end
      end
   end

   always_comb begin
      queue_in = queue_ff;
      base     = count_ff;
      if (pop) begin
         for (int i = 0; i < QDEPTH - 1; i++) begin
            queue_in[i] = queue_ff[i + 1];
         end
         base = count_ff - 3'd1;
      end
      if (nres != 2'd0) begin
         queue_in[base[1:0]] = res[0];
      end
      if (nres == 2'd2) begin
         queue_in[base[1:0] + 2'd1] = res[1];
      end
      count_in = base + {1'b0, nres};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         hcount_ff <= 2'd0;
         type_ff   <= 8'd0;
         flags_ff  <= 7'd0;
         remain_ff <= '0;
         class_ff  <= CLASS_NAMES;
         rcount_ff <= 3'd0;
         addr_ff   <= 32'd0;
         port_ff   <= 16'd0;
         count_ff  <= 3'd0;
      end else begin
         phase_ff  <= phase_in;
         hcount_ff <= hcount_in;
         type_ff   <= type_in;
         flags_ff  <= flags_in;
         remain_ff <= remain_in;
         class_ff  <= class_in;
         rcount_ff <= rcount_in;
         addr_ff   <= addr_in;
         port_ff   <= port_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      queue_ff <= queue_in;
   end

   assign rsp_chan.valid          = (count_ff != 3'd0);
   assign rsp_chan.result_kind    = queue_ff[0].result_kind;
   assign rsp_chan.packet_type    = queue_ff[0].packet_type;
   assign rsp_chan.payload_class  = queue_ff[0].payload_class;
   assign rsp_chan.header_flags   = queue_ff[0].header_flags;
   assign rsp_chan.payload_length = queue_ff[0].payload_length;
   assign rsp_chan.out_byte       = queue_ff[0].out_byte;
   assign rsp_chan.retarget_addr  = queue_ff[0].retarget_addr;
   assign rsp_chan.retarget_port  = queue_ff[0].retarget_port;
   assign rsp_chan.last           = queue_ff[0].last;

   // The queue never overfills.
   assert property (@(posedge clock) disable iff (reset) count_ff <= 3'(QDEPTH))
      else $error("result queue overflow");

   // Bytes past the packet length never produce a result.
   assert property (@(posedge clock) disable iff (reset)
      take && phase_ff == PH_DROP |-> nres == 2'd0)
      else $error("result produced in drop phase");

   // The retarget byte counter saturates at the retarget payload size.
   assert property (@(posedge clock) disable iff (reset) rcount_ff <= RETARGET_SIZE)
      else $error("retarget counter out of range");

   // An empty packet's header is its final result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.result_kind == KIND_HEADER &&
      rsp_chan.payload_length == '0 |-> rsp_chan.last)
      else $error("zero-length header not marked last");

endmodule
